// ===== design/nrbs_pkg.sv =====
// ----------------------------------------------------------------------------
// nrbs_pkg: shared definitions for the no-drop rate search
// Default widths, request and status codes and register indexes used by the
// channel interfaces and the search controller.
// ----------------------------------------------------------------------------
package nrbs_pkg;

	// default sizing
	localparam int unsigned COUNT_WIDTH    = 48;
	localparam int unsigned RATE_FRAC_BITS = 16;
	localparam int unsigned EPSILON_UNITS  = 6554;

	// rate word holds 100 percent, so seven integer bits
	localparam int unsigned RATE_INT_BITS  = 7;

	// iteration limit used when zero is programmed
	localparam logic [7:0] DEFAULT_ITER = 8'd10;
	localparam logic [7:0] ITER_MAX     = 8'hFF;

	// request codes
	typedef logic req_code_t;
	localparam req_code_t REQ_START  = 1'b0;
	localparam req_code_t REQ_REPORT = 1'b1;

	// status codes
	typedef logic [1:0] status_t;
	localparam status_t STATUS_OK   = 2'd0;
	localparam status_t STATUS_BUSY = 2'd1;
	localparam status_t STATUS_IDLE = 2'd2;

	// register indexes
	typedef logic cfg_index_t;
	localparam cfg_index_t CFG_MAX_ITER   = 1'b0;
	localparam cfg_index_t CFG_DROP_LIMIT = 1'b1;

endpackage

// ===== design/nrbs_if.sv =====
// ----------------------------------------------------------------------------
// nrbs_if: channel interfaces of the no-drop rate search
// Request channel (start / trial report), result channel and register write
// channel, each with valid and ready.
// ----------------------------------------------------------------------------

// request channel: one item per start or trial report
interface nrbs_req_if #(
	parameter int unsigned COUNT_W = nrbs_pkg::COUNT_WIDTH
);
	logic                    valid;
	logic                    ready;
	nrbs_pkg::req_code_t     req_type;
	logic [COUNT_W-1:0]      tx_count;
	logic [COUNT_W-1:0]      rx_count;
	logic [COUNT_W-1:0]      missed_count;

	modport source (output valid, req_type, tx_count, rx_count, missed_count, input ready);
	modport sink   (input valid, req_type, tx_count, rx_count, missed_count, output ready);
endinterface

// result channel: one item per request item
interface nrbs_res_if #(
	parameter int unsigned RATE_W = nrbs_pkg::RATE_INT_BITS + nrbs_pkg::RATE_FRAC_BITS
);
	logic                    valid;
	logic                    ready;
	nrbs_pkg::status_t       status;
	logic [RATE_W-1:0]       next_rate;
	logic                    trial_passed;
	logic signed [RATE_W:0]  best_rate;
	logic [7:0]              iteration;
	logic                    search_active;

	modport source (output valid, status, next_rate, trial_passed, best_rate, iteration,
		search_active, input ready);
	modport sink   (input valid, status, next_rate, trial_passed, best_rate, iteration,
		search_active, output ready);
endinterface

// register write channel
interface nrbs_cfg_if #(
	parameter int unsigned DATA_W = nrbs_pkg::RATE_INT_BITS + nrbs_pkg::RATE_FRAC_BITS
);
	logic                    valid;
	logic                    ready;
	nrbs_pkg::cfg_index_t    index;
	logic [DATA_W-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/no_drop_rate_binary_search.sv =====
// ----------------------------------------------------------------------------
// no_drop_rate_binary_search: throughput search controller
// Binary search for the highest rate with a drop percentage within the limit.
// ----------------------------------------------------------------------------
// Usage
//   req : start a search (REQ_START) or report one finished trial's tx, rx
//         and missed counts (REQ_REPORT). One result item per request item.
//   res : status, next rate to test, pass flag, best rate so far, trial count
//         and whether the search continues.
//   cfg : always ready; index 0 is the iteration limit (0 means ten), index 1
//         the drop limit in rate units. Both are latched when a search starts.
// Timing
//   Five register stages (input, products, sums, compare, result); one item
//   per cycle is sustained while the receiver is ready. The drop check
//   (limit times tx, split in two half-width products) sets the depth; the
//   search state itself is updated in the last stage.
//   Each stage moves on when the one after it is empty or moving, so a stalled
//   receiver lets the pipeline fill up before req.ready drops.
// Reset
//   arst_n clears the pipeline and leaves the search idle with limits at their
//   reset values (ten iterations, zero drop limit).
// ----------------------------------------------------------------------------
module no_drop_rate_binary_search #(
	parameter int unsigned COUNT_WIDTH    = nrbs_pkg::COUNT_WIDTH,
	parameter int unsigned RATE_FRAC_BITS = nrbs_pkg::RATE_FRAC_BITS,
	parameter int unsigned EPSILON_UNITS  = nrbs_pkg::EPSILON_UNITS
) (
	input  logic        clk,
	input  logic        arst_n,
	nrbs_cfg_if.sink    cfg,
	nrbs_req_if.sink    req,
	nrbs_res_if.source  res
);

	localparam int unsigned RATE_W = nrbs_pkg::RATE_INT_BITS + RATE_FRAC_BITS;
	localparam int unsigned HALF_W = (COUNT_WIDTH + 1) / 2;
	localparam int unsigned HI_W   = COUNT_WIDTH - HALF_W;
	localparam int unsigned CMP_W  = COUNT_WIDTH + RATE_W;
	localparam logic [RATE_W-1:0] FULL_RATE = RATE_W'(100) << RATE_FRAC_BITS;

	// ------------------------------------------------------------------
	// handshake: a stage loads when empty or when its successor loads
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, out_v_q;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_out;
	logic fire;

	assign ld_out    = !out_v_q || res.ready;
	assign ld_s4     = !v_s4 || ld_out;
	assign ld_s3     = !v_s3 || ld_s4;
	assign ld_s2     = !v_s2 || ld_s3;
	assign ld_s1     = !v_s1 || ld_s2;
	assign req.ready = ld_s1;
	assign fire      = v_s4 && ld_out;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (ld_s1)  v_s1    <= req.valid;
			if (ld_s2)  v_s2    <= v_s1;
			if (ld_s3)  v_s3    <= v_s2;
			if (ld_s4)  v_s4    <= v_s3;
			if (ld_out) out_v_q <= v_s4;
		end
	end

	// ------------------------------------------------------------------
	// registers and latched search limits
	// ------------------------------------------------------------------
	logic [7:0]        reg_iter_q;
	logic [RATE_W-1:0] reg_lim_q;
	logic [7:0]        run_iter_q;
	logic [RATE_W-1:0] run_lim_q;
	logic [RATE_W-1:0] sat_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_iter_q <= nrbs_pkg::DEFAULT_ITER;
			reg_lim_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				nrbs_pkg::CFG_MAX_ITER:   reg_iter_q <= cfg.data[7:0];
				nrbs_pkg::CFG_DROP_LIMIT: reg_lim_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// limit above 100 percent acts as 100 percent
	assign sat_lim = (reg_lim_q > FULL_RATE) ? FULL_RATE : reg_lim_q;

	// ------------------------------------------------------------------
	// stage 1: input register
	// ------------------------------------------------------------------
	nrbs_pkg::req_code_t    req_s1;
	logic [COUNT_WIDTH-1:0] tx_s1, rx_s1, missed_s1;

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			req_s1    <= req.req_type;
			tx_s1     <= req.tx_count;
			rx_s1     <= req.rx_count;
			missed_s1 <= req.missed_count;
		end
	end

	// ------------------------------------------------------------------
	// stage 1 -> 2: drops with floor at zero, limit x tx partial products.
	// Products are formed with the running limit and with the saturated
	// register value; a start ahead in the pipe can only switch to the latter.
	// ------------------------------------------------------------------
	logic [COUNT_WIDTH:0]   rcv_sum;
	logic [COUNT_WIDTH-1:0] drops_c;
	logic [HALF_W-1:0]      tx_lo;
	logic [HI_W-1:0]        tx_hi;

	assign rcv_sum = {1'b0, rx_s1} + {1'b0, missed_s1};
	assign drops_c = ({1'b0, tx_s1} > rcv_sum) ? (tx_s1 - rcv_sum[COUNT_WIDTH-1:0]) : '0;
	assign tx_lo   = tx_s1[HALF_W-1:0];
	assign tx_hi   = tx_s1[COUNT_WIDTH-1:HALF_W];

	nrbs_pkg::req_code_t    req_s2;
	logic                   txz_s2;
	logic [RATE_W-1:0]      lim_a_s2;
	logic [COUNT_WIDTH-1:0] drops_s2;
	logic [RATE_W+HALF_W-1:0] ppa_lo_s2, ppb_lo_s2;
	logic [RATE_W+HI_W-1:0]   ppa_hi_s2, ppb_hi_s2;

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			req_s2    <= req_s1;
			txz_s2    <= (tx_s1 == '0);
			lim_a_s2  <= run_lim_q;
			drops_s2  <= drops_c;
			ppa_lo_s2 <= (RATE_W+HALF_W)'(run_lim_q) * (RATE_W+HALF_W)'(tx_lo);
			ppa_hi_s2 <= (RATE_W+HI_W)'(run_lim_q) * (RATE_W+HI_W)'(tx_hi);
			ppb_lo_s2 <= (RATE_W+HALF_W)'(sat_lim) * (RATE_W+HALF_W)'(tx_lo);
			ppb_hi_s2 <= (RATE_W+HI_W)'(sat_lim) * (RATE_W+HI_W)'(tx_hi);
		end
	end

	// ------------------------------------------------------------------
	// stage 2 -> 3: drops x 100 x 2^F, sum of partial products
	// ------------------------------------------------------------------
	logic [COUNT_WIDTH+6:0] d100;
	assign d100 = ((COUNT_WIDTH+7)'(drops_s2) << 6) + ((COUNT_WIDTH+7)'(drops_s2) << 5)
		+ ((COUNT_WIDTH+7)'(drops_s2) << 2);

	nrbs_pkg::req_code_t req_s3;
	logic                txz_s3;
	logic [RATE_W-1:0]   lim_a_s3;
	logic [CMP_W-1:0]    lhs_s3, rhs_a_s3, rhs_b_s3;

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			req_s3   <= req_s2;
			txz_s3   <= txz_s2;
			lim_a_s3 <= lim_a_s2;
			lhs_s3   <= CMP_W'(d100) << RATE_FRAC_BITS;
			rhs_a_s3 <= (CMP_W'(ppa_hi_s2) << HALF_W) + CMP_W'(ppa_lo_s2);
			rhs_b_s3 <= (CMP_W'(ppb_hi_s2) << HALF_W) + CMP_W'(ppb_lo_s2);
		end
	end

	// ------------------------------------------------------------------
	// stage 3 -> 4: drop comparison against both candidate limits
	// ------------------------------------------------------------------
	nrbs_pkg::req_code_t req_s4;
	logic                txz_s4;
	logic [RATE_W-1:0]   lim_a_s4;
	logic                pass_a_s4, pass_b_s4;

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			req_s4    <= req_s3;
			txz_s4    <= txz_s3;
			lim_a_s4  <= lim_a_s3;
			pass_a_s4 <= (lhs_s3 <= rhs_a_s3);
			pass_b_s4 <= (lhs_s3 <= rhs_b_s3);
		end
	end

	// ------------------------------------------------------------------
	// stage 4 -> result: search state update
	// ------------------------------------------------------------------
	logic                   active_q;
	logic [RATE_W-1:0]      low_q, high_q, cur_q;
	logic signed [RATE_W:0] best_q;
	logic [7:0]             trials_q;

	logic                   active_n;
	logic [RATE_W-1:0]      low_n, high_n, cur_n;
	logic signed [RATE_W:0] best_n;
	logic [7:0]             trials_n, iter_n;
	logic [RATE_W-1:0]      lim_n;
	logic [RATE_W:0]        mid_sum;
	logic [RATE_W-1:0]      span;
	logic                   pass, finish;
	nrbs_pkg::status_t      status_n;
	logic [RATE_W-1:0]      next_n;
	logic                   passed_n;

	// zero tx counts as full drop; otherwise pick the product of the limit in force
	assign pass = txz_s4 ? (run_lim_q == FULL_RATE)
		: ((run_lim_q == lim_a_s4) ? pass_a_s4 : pass_b_s4);

	always_comb begin
		active_n = active_q;
		low_n    = low_q;
		high_n   = high_q;
		cur_n    = cur_q;
		best_n   = best_q;
		trials_n = trials_q;
		iter_n   = run_iter_q;
		lim_n    = run_lim_q;
		status_n = nrbs_pkg::STATUS_OK;
		next_n   = '0;
		passed_n = 1'b0;
		mid_sum  = '0;
		span     = '0;
		finish   = 1'b0;
		unique case (req_s4)
			nrbs_pkg::REQ_START: begin
				if (active_q) begin
					status_n = nrbs_pkg::STATUS_BUSY;
				end else begin
					iter_n   = (reg_iter_q != 8'd0) ? reg_iter_q : nrbs_pkg::DEFAULT_ITER;
					lim_n    = sat_lim;
					low_n    = '0;
					high_n   = FULL_RATE;
					best_n   = '1;
					trials_n = 8'd0;
					active_n = 1'b1;
					cur_n    = FULL_RATE >> 1;
					next_n   = FULL_RATE >> 1;
				end
			end
			nrbs_pkg::REQ_REPORT: begin
				if (!active_q) begin
					status_n = nrbs_pkg::STATUS_IDLE;
				end else begin
					passed_n = pass;
					if (pass) begin
						best_n = $signed({1'b0, cur_q});
						low_n  = cur_q;
					end else begin
						high_n = cur_q;
					end
					if (trials_q != nrbs_pkg::ITER_MAX) trials_n = trials_q + 8'd1;
					span    = high_n - low_n;
					mid_sum = {1'b0, low_n} + {1'b0, high_n};
					finish  = (trials_n >= run_iter_q) || (high_n <= low_n)
						|| (32'(span) < 32'(EPSILON_UNITS));
					if (finish) begin
						active_n = 1'b0;
					end else begin
						cur_n  = mid_sum[RATE_W:1];
						next_n = mid_sum[RATE_W:1];
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			low_q      <= '0;
			high_q     <= FULL_RATE;
			cur_q      <= '0;
			best_q     <= '1;
			trials_q   <= 8'd0;
			run_iter_q <= nrbs_pkg::DEFAULT_ITER;
			run_lim_q  <= '0;
		end else if (fire) begin
			active_q   <= active_n;
			low_q      <= low_n;
			high_q     <= high_n;
			cur_q      <= cur_n;
			best_q     <= best_n;
			trials_q   <= trials_n;
			run_iter_q <= iter_n;
			run_lim_q  <= lim_n;
		end
	end

	// result register
	nrbs_pkg::status_t      out_status_q;
	logic [RATE_W-1:0]      out_next_q;
	logic                   out_passed_q;
	logic signed [RATE_W:0] out_best_q;
	logic [7:0]             out_iter_q;
	logic                   out_active_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			out_status_q <= status_n;
			out_next_q   <= next_n;
			out_passed_q <= passed_n;
			out_best_q   <= best_n;
			out_iter_q   <= trials_n;
			out_active_q <= active_n;
		end
	end

	assign res.valid         = out_v_q;
	assign res.status        = out_status_q;
	assign res.next_rate     = out_next_q;
	assign res.trial_passed  = out_passed_q;
	assign res.best_rate     = out_best_q;
	assign res.iteration     = out_iter_q;
	assign res.search_active = out_active_q;

endmodule

// ===== verif/nrbs_result_checker.sv =====
// ----------------------------------------------------------------------------
// nrbs_result_checker: result checking for the no-drop rate search
// Watches the register, request and result channels. Keeps its own copy of
// the search state and works out the result of every accepted request item,
// then compares each accepted result item field by field with the oldest one
// still awaited. Hands the failure count and the number of awaited results
// to the testbench top.
// ----------------------------------------------------------------------------
module nrbs_result_checker (
	input  logic clk,
	input  logic arst_n,
	nrbs_cfg_if  cfg,
	nrbs_req_if  req,
	nrbs_res_if  res,
	output int   fail_count,
	output int   awaited
);
	import nrbs_pkg::*;

	localparam int RATE_W = RATE_INT_BITS + RATE_FRAC_BITS;
	localparam int CW     = COUNT_WIDTH;
	localparam logic [RATE_W-1:0] FULL_RATE = RATE_W'(100) << RATE_FRAC_BITS;
	localparam int SHOW_LIMIT = 10;

	typedef struct packed {
		status_t              status;
		logic [RATE_W-1:0]    next_rate;
		logic                 passed;
		logic signed [RATE_W:0] best;
		logic [7:0]           iteration;
		logic                 active;
	} search_result_t;

	// programmed registers and the copies latched at search start
	logic [7:0]          reg_iter;
	logic [RATE_W-1:0]   reg_limit;
	logic [7:0]          run_iter;
	logic [RATE_W-1:0]   run_limit;

	// search state
	logic                   searching;
	logic [RATE_W-1:0]      low_rate;
	logic [RATE_W-1:0]      high_rate;
	logic [RATE_W-1:0]      cur_rate;
	logic signed [RATE_W:0] best_rate;
	logic [7:0]             trials;

	search_result_t awaited_results[$];
	int shown;

	// one search step: updates the state and returns the result item
	function automatic search_result_t next_search_result(input req_code_t kind,
			input logic [CW-1:0] tx, input logic [CW-1:0] rx, input logic [CW-1:0] missed);
		search_result_t    r;
		status_t           st;
		logic [RATE_W-1:0] next;
		logic              ok;
		logic [CW-1:0]     drops;
		logic [127:0]      drop_scaled;
		logic [127:0]      limit_scaled;
		st   = STATUS_OK;
		next = '0;
		ok   = 1'b0;
		if (kind == REQ_START) begin
			if (searching) begin
				st = STATUS_BUSY;
			end else begin
				run_iter  = (reg_iter == 8'd0) ? DEFAULT_ITER : reg_iter;
				run_limit = (reg_limit > FULL_RATE) ? FULL_RATE : reg_limit;
				low_rate  = '0;
				high_rate = FULL_RATE;
				best_rate = -1;
				trials    = 8'd0;
				searching = 1'b1;
				cur_rate  = RATE_W'(({1'b0, low_rate} + {1'b0, high_rate}) >> 1);
				next      = cur_rate;
			end
		end else if (!searching) begin
			st = STATUS_IDLE;
		end else begin
			// no packets sent counts as everything dropped
			if (tx == '0) begin
				ok = (run_limit >= FULL_RATE);
			end else begin
				drops = '0;
				if (tx > rx && (tx - rx) > missed)
					drops = tx - rx - missed;
				drop_scaled  = 128'(drops) * 128'(FULL_RATE);
				limit_scaled = 128'(run_limit) * 128'(tx);
				ok = (drop_scaled <= limit_scaled);
			end
			if (ok) begin
				best_rate = $signed({1'b0, cur_rate});
				low_rate  = cur_rate;
			end else begin
				high_rate = cur_rate;
			end
			if (trials != ITER_MAX)
				trials = trials + 8'd1;
			if (trials >= run_iter || high_rate <= low_rate ||
					(high_rate - low_rate) < RATE_W'(EPSILON_UNITS)) begin
				searching = 1'b0;
			end else begin
				cur_rate = RATE_W'(({1'b0, low_rate} + {1'b0, high_rate}) >> 1);
				next     = cur_rate;
			end
		end
		r.status    = st;
		r.next_rate = next;
		r.passed    = ok;
		r.best      = best_rate;
		r.iteration = trials;
		r.active    = searching;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		search_result_t want;
		search_result_t got;
		if (!arst_n) begin
			reg_iter   = DEFAULT_ITER;
			reg_limit  = '0;
			run_iter   = DEFAULT_ITER;
			run_limit  = '0;
			searching  = 1'b0;
			low_rate   = '0;
			high_rate  = FULL_RATE;
			cur_rate   = '0;
			best_rate  = -1;
			trials     = 8'd0;
			fail_count = 0;
			shown      = 0;
			awaited_results.delete();
			awaited   <= 0;
		end else begin
			// register writes
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_MAX_ITER)
					reg_iter = cfg.data[7:0];
				else if (cfg.index == CFG_DROP_LIMIT)
					reg_limit = cfg.data;
			end
			// request items
			if (req.valid && req.ready)
				awaited_results.push_back(next_search_result(req.req_type, req.tx_count,
					req.rx_count, req.missed_count));
			// result items
			if (res.valid && res.ready) begin
				got.status    = res.status;
				got.next_rate = res.next_rate;
				got.passed    = res.trial_passed;
				got.best      = res.best_rate;
				got.iteration = res.iteration;
				got.active    = res.search_active;
				if (awaited_results.size() == 0) begin
					fail_count = fail_count + 1;
					if (shown < SHOW_LIMIT) begin
						shown = shown + 1;
						$display("nrbs check: result item at %0t with nothing awaited", $time);
					end
				end else begin
					want = awaited_results.pop_front();
					if (got.status !== want.status || got.next_rate !== want.next_rate ||
							got.passed !== want.passed || got.best !== want.best ||
							got.iteration !== want.iteration ||
							got.active !== want.active) begin
						fail_count = fail_count + 1;
						if (shown < SHOW_LIMIT) begin
							shown = shown + 1;
							$display("nrbs check: mismatch at %0t (expected / actual)", $time);
							$display("  status %0d / %0d  next_rate %0d / %0d  passed %0b / %0b",
								want.status, got.status, want.next_rate, got.next_rate,
								want.passed, got.passed);
							$display("  best %0d / %0d  iteration %0d / %0d  active %0b / %0b",
								want.best, got.best, want.iteration, got.iteration,
								want.active, got.active);
						end
					end
				end
			end
			awaited <= awaited_results.size();
		end
	end

endmodule

// ===== verif/no_drop_rate_binary_search_tb.sv =====
// ----------------------------------------------------------------------------
// no_drop_rate_binary_search_tb: testbench top for the no-drop rate search
// Drives start and trial report items and register writes, with phases of
// sender gaps and receiver stalls and one long receiver hold-off. Checking is
// done by the result checker beside the block; this top gives the verdict.
// ----------------------------------------------------------------------------
module no_drop_rate_binary_search_tb;
	import nrbs_pkg::*;

	localparam int RATE_W = RATE_INT_BITS + RATE_FRAC_BITS;
	localparam int CW     = COUNT_WIDTH;
	localparam logic [RATE_W-1:0] FULL_RATE = RATE_W'(100) << RATE_FRAC_BITS;
	localparam int RANDOM_ITEMS = 1900;
	localparam int PHASE_ITEMS  = RANDOM_ITEMS / 4;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 10;

	typedef enum logic [1:0] {
		PACE_FULL,
		PACE_SRC_IDLE,
		PACE_SNK_STALL,
		PACE_BOTH
	} pace_t;

	logic  clk = 1'b0;
	logic  arst_n;
	pace_t pace = PACE_FULL;
	logic  hold_wanted = 1'b0;
	int    sent_items = 0;
	int    quiet_cycles = 0;
	int    fail_count;
	int    awaited;

	// limits as last written, used to aim reports near the pass boundary
	logic [7:0]        eff_iter  = DEFAULT_ITER;
	logic [RATE_W-1:0] eff_limit = '0;

	nrbs_req_if req_ch();
	nrbs_res_if res_ch();
	nrbs_cfg_if cfg_ch();

	no_drop_rate_binary_search dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.res    (res_ch)
	);

	nrbs_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_ch),
		.req        (req_ch),
		.res        (res_ch),
		.fail_count (fail_count),
		.awaited    (awaited)
	);

	always #2 clk = ~clk;

	function automatic int gap_pct();
		return (pace == PACE_SRC_IDLE) ? 75 : (pace == PACE_BOTH) ? 38 : 0;
	endfunction

	function automatic int stall_pct();
		return (pace == PACE_SNK_STALL) ? 75 : (pace == PACE_BOTH) ? 38 : 0;
	endfunction

	// counter value of random magnitude, up to the full width
	function automatic logic [CW-1:0] rand_count();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return CW'(w >> $urandom_range(64 - CW, 63));
	endfunction

	// result side: random stalls, and one long hold-off on request
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_wanted) begin
				hold_wanted = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			res_ch.ready <= ($urandom_range(99) >= stall_pct());
		end
	end

	// watchdog: ends the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("no_drop_rate_binary_search_tb: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one request item, with random gaps ahead of it
	task automatic put_req(input req_code_t kind, input logic [CW-1:0] tx,
			input logic [CW-1:0] rx, input logic [CW-1:0] missed);
		while ($urandom_range(99) < gap_pct()) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.req_type     <= kind;
		req_ch.tx_count     <= tx;
		req_ch.rx_count     <= rx;
		req_ch.missed_count <= missed;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		@(negedge clk);
		sent_items++;
	endtask

	// trial report: mostly drop counts close to the limit, some noise
	task automatic put_report();
		logic [CW-1:0] tx;
		logic [CW-1:0] rx;
		logic [CW-1:0] missed;
		logic [CW-1:0] keep;
		logic [127:0]  wide;
		logic [63:0]   drops;
		case ($urandom_range(9))
			0: begin
				tx     = '0;
				rx     = rand_count();
				missed = rand_count();
			end
			1: begin
				tx     = rand_count();
				rx     = rand_count();
				missed = rand_count();
			end
			default: begin
				tx    = ($urandom_range(3) == 0) ? CW'($urandom_range(1, 2000)) : rand_count();
				wide  = 128'(tx) * 128'(eff_limit) / 128'(FULL_RATE);
				drops = 64'(wide) + 64'($urandom_range(4));
				drops = (drops < 64'd2) ? 64'd0 : drops - 64'd2;
				if (drops > 64'(tx))
					drops = 64'(tx);
				keep   = tx - CW'(drops);
				missed = ($urandom_range(1) == 0) ? '0 :
					CW'({$urandom, $urandom} % (64'(keep) + 64'd1));
				rx     = keep - missed;
			end
		endcase
		put_req(REQ_REPORT, tx, rx, missed);
	endtask

	// start plus a run of reports, now and then a start in the middle
	task automatic run_search();
		int n_reports;
		n_reports = (eff_iter == 8'd0 || eff_iter > 8'd10) ? 10 : int'(eff_iter);
		if ($urandom_range(4) == 0)
			n_reports = $urandom_range(1, 12);
		put_req(REQ_START, rand_count(), rand_count(), rand_count());
		repeat (n_reports) begin
			if ($urandom_range(19) == 0)
				put_req(REQ_START, rand_count(), rand_count(), rand_count());
			put_report();
		end
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [RATE_W-1:0] word);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= word;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// both registers, in random order
	task automatic set_regs(input logic [RATE_W-1:0] iter_word,
			input logic [RATE_W-1:0] limit_word);
		if ($urandom_range(1) == 0) begin
			write_reg(CFG_MAX_ITER, iter_word);
			write_reg(CFG_DROP_LIMIT, limit_word);
		end else begin
			write_reg(CFG_DROP_LIMIT, limit_word);
			write_reg(CFG_MAX_ITER, iter_word);
		end
		cfg_ch.valid <= 1'b0;
		eff_iter  = iter_word[7:0];
		eff_limit = (limit_word > FULL_RATE) ? FULL_RATE : limit_word;
	endtask

	// let every awaited result come back
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (awaited != 0) @(negedge clk);
	endtask

	// iteration limit word; upper bits are random and must be ignored
	function automatic logic [RATE_W-1:0] pick_iter(input int batch);
		logic [RATE_W-1:0] w;
		w = RATE_W'($urandom);
		case (batch % 6)
			0: w[7:0] = DEFAULT_ITER;
			1: w[7:0] = 8'd1;
			2: w[7:0] = ITER_MAX;
			3: w[7:0] = 8'd0;
			default: w[7:0] = 8'($urandom_range(2, 254));
		endcase
		return w;
	endfunction

	function automatic logic [RATE_W-1:0] pick_limit(input int batch);
		case (batch % 6)
			0: return '0;
			1: return FULL_RATE;
			2: return '1;
			3: return RATE_W'($urandom_range(int'(FULL_RATE)));
			4: return RATE_W'($urandom_range(1, 5 << RATE_FRAC_BITS));
			default: return RATE_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [CW-1:0] all_ones;
		int batch;
		int phase_end;
		all_ones = '1;
		arst_n   = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.req_type     = REQ_START;
		req_ch.tx_count     = '0;
		req_ch.rx_count     = '0;
		req_ch.missed_count = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_MAX_ITER;
		cfg_ch.data  = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset limits (ten trials, zero drop limit)
		put_req(REQ_REPORT, all_ones, '0, '0);        // report while idle
		put_req(REQ_START, '0, '0, '0);
		put_req(REQ_START, all_ones, all_ones, all_ones); // start while searching
		put_req(REQ_REPORT, '0, all_ones, all_ones);  // nothing sent: full drop
		put_req(REQ_REPORT, all_ones, all_ones, '0);  // no drops at full counts
		put_req(REQ_REPORT, CW'(5), all_ones, all_ones); // more received than sent
		put_req(REQ_REPORT, all_ones, '0, '0);        // everything dropped
		put_req(REQ_REPORT, CW'(1), '0, CW'(1));      // missed counts as received
		put_req(REQ_REPORT, all_ones, '0, all_ones);
		put_req(REQ_REPORT, CW'(1000), CW'(999), '0); // one drop against a zero limit
		repeat (3) put_report();
		put_req(REQ_REPORT, CW'(7), CW'(7), '0);      // search over: idle again

		// one trial per search, drop limit above full scale saturates
		drain();
		set_regs({15'h7FFF, 8'd1}, '1);
		put_req(REQ_START, '0, '0, '0);
		put_req(REQ_REPORT, '0, '0, '0);

		// zero iteration limit means ten, limit exactly full scale
		drain();
		set_regs('0, FULL_RATE);
		put_req(REQ_START, '0, '0, '0);
		put_req(REQ_REPORT, '0, all_ones, '0);
		put_req(REQ_REPORT, all_ones, '0, '0);

		// random part, one pacing per phase
		batch = 0;
		for (int p = 0; p < 4; p++) begin
			pace      = pace_t'(p);
			phase_end = sent_items + PHASE_ITEMS;
			while (sent_items < phase_end) begin
				drain();
				set_regs(pick_iter(batch), pick_limit(batch));
				// long receiver hold-off while the sender keeps going
				if (batch == 0)
					hold_wanted = 1'b1;
				repeat ((batch == 0) ? 3 : $urandom_range(1, 3)) run_search();
				if ($urandom_range(3) == 0)
					put_report();
				batch++;
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && awaited == 0)
			$display("no_drop_rate_binary_search_tb: PASS");
		else
			$display("no_drop_rate_binary_search_tb: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
design/nrbs_pkg.sv
design/nrbs_if.sv
design/no_drop_rate_binary_search.sv
verif/nrbs_result_checker.sv
verif/no_drop_rate_binary_search_tb.sv
